[rtl/core/gedw_pkg.sv]
`timescale 1ns / 1ps
// gedw_pkg: shared widths, register indexes, reset values, result beat type
// and the min/max pick used by the window reductions. No dependencies.
package gedw_pkg;

    localparam int PIX_W             = 8;
    localparam int X_OUT_W           = 10;
    localparam int Y_W               = 10;
    localparam int H_W               = 11;
    localparam int MAX_REGION_HEIGHT = 1024;
    localparam int KSZ_W             = 5;
    localparam int KSZ_CMP_W         = 6;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 11;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = 3'd4;

    localparam logic [KSZ_W-1:0]      RST_KERNEL_ROWS   = 5'd3;
    localparam logic [KSZ_W-1:0]      RST_KERNEL_COLS   = 5'd3;
    localparam logic                  RST_OPERATION     = 1'b0;
    localparam logic [CFG_DATA_W-1:0] RST_REGION_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_REGION_HEIGHT = 11'd480;

    typedef struct packed {
        logic [X_OUT_W-1:0] x;
        logic [Y_W-1:0]     y;
        logic [PIX_W-1:0]   value;
        logic               filtered;
        logic               size_error;
        logic               last_of_item;
        logic               frame_done;
    } result_t;

    function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic dilate);
        logic [PIX_W-1:0] r;
        if (dilate) begin
            r = (b > a) ? b : a;
        end else begin
            r = (b < a) ? b : a;
        end
        return r;
    endfunction

endpackage

[rtl/core/gedw_line_mem.sv]
`timescale 1ns / 1ps
// gedw_line_mem: line store, one row per column holding every kept line,
// registered read port and one write port. Depends on nothing.
module gedw_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 120
) (
    input  logic          aclk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gedw_reduce.sv]
`timescale 1ns / 1ps
// gedw_reduce: masked min/max over a row of lanes, groups of four reduced
// into registers, then the group values chained. Depends on gedw_pkg.
module gedw_reduce #(
    parameter int LANES = 16
) (
    input  logic                                  aclk,
    input  logic                                  load,
    input  logic                                  dilate,
    input  logic [LANES-1:0][gedw_pkg::PIX_W-1:0] lanes,
    input  logic [LANES-1:0]                      lane_ok,
    output logic [gedw_pkg::PIX_W-1:0]            result
);

    localparam int GROUPS = (LANES + 3) / 4;

    logic [gedw_pkg::PIX_W-1:0] grp_reg  [GROUPS];
    logic [gedw_pkg::PIX_W-1:0] grp_next [GROUPS];
    logic [gedw_pkg::PIX_W-1:0] neutral;

    assign neutral = dilate ? gedw_pkg::PIX_MIN : gedw_pkg::PIX_MAX;

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_next[g] = neutral;
            for (int i = 0; i < 4; i++) begin
                if (4 * g + i < LANES) begin
                    if (lane_ok[4 * g + i]) begin
                        grp_next[g] = gedw_pkg::pick(grp_next[g], lanes[4 * g + i], dilate);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp_next;
        end
    end

    always_comb begin
        result = neutral;
        for (int g = 0; g < GROUPS; g++) begin
            result = gedw_pkg::pick(result, grp_reg[g], dilate);
        end
    end

endmodule

[rtl/core/gedw_out_queue.sv]
`timescale 1ns / 1ps
// gedw_out_queue: two-entry result queue between the window logic and the
// m_ channel; takes up to two beats at once. Depends on gedw_pkg.
module gedw_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [1:0]          push_n,
    input  gedw_pkg::result_t   item_a,
    input  gedw_pkg::result_t   item_b,
    input  logic                pop_ready,
    output gedw_pkg::result_t   head,
    output logic                head_valid,
    output logic [1:0]          free
);

    localparam logic [1:0] DEPTH = 2'd2;

    gedw_pkg::result_t q_reg  [2];
    gedw_pkg::result_t q_next [2];
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [1:0]        cnt_mid;
    logic              pop;

    assign pop = (cnt_reg != 2'd0) && pop_ready;

    always_comb begin
        q_next   = q_reg;
        cnt_mid  = cnt_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            cnt_mid   = cnt_reg - 2'd1;
        end
        cnt_next = cnt_mid;
        if (push && push_n != 2'd0) begin
            cnt_next = cnt_mid + push_n;
            if (cnt_mid == 2'd0) begin
                q_next[0] = item_a;
                q_next[1] = item_b;
            end else begin
                q_next[1] = item_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign head       = q_reg[0];
    assign head_valid = (cnt_reg != 2'd0);
    assign free       = DEPTH - cnt_reg;

endmodule

[rtl/core/grayscale_erode_dilate_window.sv]
`timescale 1ns / 1ps
// grayscale_erode_dilate_window: rectangular grayscale erosion / dilation
// over a raster pixel stream. Uses gedw_pkg, gedw_line_mem, gedw_reduce,
// gedw_out_queue.
//
//  channel  dir  handshake              payload
//  s_       in   s_valid / s_ready      s_pixel
//  m_       out  m_valid / m_ready      m_out_x, m_out_y, m_out_value, m_is_filtered,
//                                       m_size_error, m_last_of_item, m_frame_done
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a pixel that fits the kernel passes beat, line memory read and write back,
// column reduce, row reduce and queue, a size error goes from beat to queue;
// the line memory read-modify-write and the two registered reductions are
// the steps between. s_ready is low while a pixel is in work; a queue without
// room for the pixel's beats holds it in its last step until room frees up
// synchronous reset clears control and counters and loads the register reset
// values; line memory and column history are not cleared, cfg_ready is always high
module grayscale_erode_dilate_window #(
    parameter int MAX_LINE_WIDTH  = 1024,
    parameter int MAX_KERNEL_ROWS = 16,
    parameter int MAX_KERNEL_COLS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [gedw_pkg::PIX_W-1:0]        s_pixel,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gedw_pkg::X_OUT_W-1:0]      m_out_x,
    output logic [gedw_pkg::Y_W-1:0]          m_out_y,
    output logic [gedw_pkg::PIX_W-1:0]        m_out_value,
    output logic                              m_is_filtered,
    output logic                              m_size_error,
    output logic                              m_last_of_item,
    output logic                              m_frame_done,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gedw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gedw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SLOTS = MAX_KERNEL_ROWS - 1;
    localparam int XW    = $clog2(MAX_LINE_WIDTH);
    localparam int WW    = $clog2(MAX_LINE_WIDTH + 1);
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KRW   = $clog2(MAX_KERNEL_ROWS + 1);
    localparam int KCW   = $clog2(MAX_KERNEL_COLS + 1);
    localparam int YW    = gedw_pkg::Y_W;
    localparam int HW    = gedw_pkg::H_W;
    localparam int OXW   = gedw_pkg::X_OUT_W;
    localparam int KSW   = gedw_pkg::KSZ_W;
    localparam int KCMPW = gedw_pkg::KSZ_CMP_W;
    localparam int CDW   = gedw_pkg::CFG_DATA_W;
    localparam int PW    = gedw_pkg::PIX_W;
    localparam int WCMPW = (WW > CDW) ? WW : CDW;
    localparam int XSW   = WW + 1;
    localparam int YSW   = HW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COL,
        S_ROW,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [KSW-1:0] kr_reg, kc_reg;
    logic           op_reg;
    logic [CDW-1:0] rw_reg, rh_reg;

    logic [XW-1:0]  x_reg;
    logic [YW-1:0]  y_reg;
    logic [SW-1:0]  slot_reg;

    logic [PW-1:0]  p_reg;
    logic [XW-1:0]  px_reg;
    logic [YW-1:0]  py_reg;
    logic [SW-1:0]  pslot_reg;
    logic           last_reg;
    logic           err_reg;

    logic [MAX_KERNEL_COLS-1:0][PW-1:0] hist_reg;

    logic [KRW-1:0] nr;
    logic [KCW-1:0] nc;
    logic [WW-1:0]  w;
    logic [HW-1:0]  h;
    logic           err_now;

    logic           accept;
    logic           cfg_wr;
    logic           cfg_hit;

    logic [SLOTS-1:0][PW-1:0] mem_rdata;
    logic [SLOTS-1:0][PW-1:0] mem_wdata;
    logic                     mem_we;

    logic [MAX_KERNEL_ROWS-1:0][PW-1:0] col_lanes;
    logic [MAX_KERNEL_ROWS-1:0]         col_ok;
    logic [PW-1:0]                      col_v;
    logic [MAX_KERNEL_COLS-1:0]         row_ok;
    logic [PW-1:0]                      row_e;

    gedw_pkg::result_t res_a, res_b, q_head;
    logic [1:0]        res_n;
    logic [1:0]        q_free;
    logic              q_push;

    // effective register values
    always_comb begin
        if (kr_reg == '0) begin
            nr = KRW'(1);
        end else if (KCMPW'(kr_reg) > KCMPW'(MAX_KERNEL_ROWS)) begin
            nr = KRW'(MAX_KERNEL_ROWS);
        end else begin
            nr = KRW'(kr_reg);
        end
        if (kc_reg == '0) begin
            nc = KCW'(1);
        end else if (KCMPW'(kc_reg) > KCMPW'(MAX_KERNEL_COLS)) begin
            nc = KCW'(MAX_KERNEL_COLS);
        end else begin
            nc = KCW'(kc_reg);
        end
        if (rw_reg == '0) begin
            w = WW'(1);
        end else if (WCMPW'(rw_reg) > WCMPW'(MAX_LINE_WIDTH)) begin
            w = WW'(MAX_LINE_WIDTH);
        end else begin
            w = WW'(rw_reg);
        end
        if (rh_reg == '0) begin
            h = HW'(1);
        end else if (rh_reg > HW'(gedw_pkg::MAX_REGION_HEIGHT)) begin
            h = HW'(gedw_pkg::MAX_REGION_HEIGHT);
        end else begin
            h = rh_reg;
        end
        err_now = (WCMPW'(nc) > WCMPW'(w)) || (HW'(nr) > h);
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_wr && (cfg_index == gedw_pkg::CFG_KERNEL_ROWS
                                || cfg_index == gedw_pkg::CFG_KERNEL_COLS
                                || cfg_index == gedw_pkg::CFG_OPERATION
                                || cfg_index == gedw_pkg::CFG_REGION_WIDTH
                                || cfg_index == gedw_pkg::CFG_REGION_HEIGHT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = err_now ? S_OUT : S_READ;
                end
            end
            S_READ: state_next = S_COL;
            S_COL:  state_next = S_ROW;
            S_ROW:  state_next = S_OUT;
            S_OUT: begin
                if (q_push) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kr_reg    <= gedw_pkg::RST_KERNEL_ROWS;
            kc_reg    <= gedw_pkg::RST_KERNEL_COLS;
            op_reg    <= gedw_pkg::RST_OPERATION;
            rw_reg    <= gedw_pkg::RST_REGION_WIDTH;
            rh_reg    <= gedw_pkg::RST_REGION_HEIGHT;
            x_reg     <= '0;
            y_reg     <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (cfg_index)
                    gedw_pkg::CFG_KERNEL_ROWS:   kr_reg <= cfg_data[KSW-1:0];
                    gedw_pkg::CFG_KERNEL_COLS:   kc_reg <= cfg_data[KSW-1:0];
                    gedw_pkg::CFG_OPERATION:     op_reg <= cfg_data[0];
                    gedw_pkg::CFG_REGION_WIDTH:  rw_reg <= cfg_data;
                    gedw_pkg::CFG_REGION_HEIGHT: rh_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                x_reg    <= '0;
                y_reg    <= '0;
                slot_reg <= '0;
            end else if (accept) begin
                if (WW'(x_reg) + WW'(1) >= w) begin
                    x_reg <= '0;
                    if (HW'(y_reg) + HW'(1) >= h) begin
                        y_reg    <= '0;
                        slot_reg <= '0;
                    end else begin
                        y_reg    <= y_reg + YW'(1);
                        slot_reg <= (slot_reg == SW'(SLOTS - 1)) ? '0 : slot_reg + SW'(1);
                    end
                end else begin
                    x_reg <= x_reg + XW'(1);
                end
            end
        end
    end

    // pixel beat held for its whole pass
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_reg     <= s_pixel;
            px_reg    <= x_reg;
            py_reg    <= y_reg;
            pslot_reg <= slot_reg;
            last_reg  <= (WW'(x_reg) == w - WW'(1)) && (HW'(y_reg) == h - HW'(1));
            err_reg   <= err_now;
        end
    end

    assign mem_we = (state_reg == S_READ);

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            mem_wdata[j] = (SW'(j) == pslot_reg) ? p_reg : mem_rdata[j];
        end
    end

    gedw_line_mem #(
        .DEPTH (MAX_LINE_WIDTH),
        .AW    (XW),
        .DW    (SLOTS * PW)
    ) u_line_mem (
        .aclk  (aclk),
        .re    (accept),
        .raddr (x_reg),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (px_reg),
        .wdata (mem_wdata)
    );

    // slot j holds the line k rows above, k in 1..SLOTS
    always_comb begin
        logic [KRW-1:0] ps;
        logic [KRW-1:0] jj;
        logic [KRW-1:0] kk;
        col_lanes[0] = p_reg;
        col_ok[0]    = 1'b1;
        for (int j = 0; j < SLOTS; j++) begin
            ps = KRW'(pslot_reg);
            jj = KRW'(j);
            kk = (ps > jj) ? ps - jj : ps + KRW'(SLOTS) - jj;
            col_lanes[j + 1] = mem_rdata[j];
            col_ok[j + 1]    = (kk < nr) && (YW'(kk) <= py_reg);
        end
    end

    gedw_reduce #(
        .LANES (MAX_KERNEL_ROWS)
    ) u_col_reduce (
        .aclk    (aclk),
        .load    (state_reg == S_READ),
        .dilate  (op_reg),
        .lanes   (col_lanes),
        .lane_ok (col_ok),
        .result  (col_v)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == S_COL) begin
            hist_reg <= {hist_reg[MAX_KERNEL_COLS-2:0], col_v};
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_KERNEL_COLS; k++) begin
            row_ok[k] = (KCW'(k) < nc);
        end
    end

    gedw_reduce #(
        .LANES (MAX_KERNEL_COLS)
    ) u_row_reduce (
        .aclk    (aclk),
        .load    (state_reg == S_ROW),
        .dilate  (op_reg),
        .lanes   (hist_reg),
        .lane_ok (row_ok),
        .result  (row_e)
    );

    // result beats of the current pixel
    always_comb begin
        logic [KCW-1:0]  c2;
        logic [KRW-1:0]  r2;
        logic [XSW-1:0]  x_hi;
        logic [YSW-1:0]  y_hi;
        logic [XSW-1:0]  wx;
        logic [YSW-1:0]  wy;
        logic            interior;
        logic            win;
        gedw_pkg::result_t border_r;
        gedw_pkg::result_t win_r;
        c2   = nc >> 1;
        r2   = nr >> 1;
        x_hi = XSW'(c2) + XSW'(w) - XSW'(nc);
        y_hi = YSW'(r2) + YSW'(h) - YSW'(nr);
        interior = (XSW'(px_reg) >= XSW'(c2)) && (XSW'(px_reg) <= x_hi)
                && (YSW'(py_reg) >= YSW'(r2)) && (YSW'(py_reg) <= y_hi);
        win = (XSW'(px_reg) + XSW'(1) >= XSW'(nc)) && (YSW'(py_reg) + YSW'(1) >= YSW'(nr));
        wx  = XSW'(px_reg) + XSW'(c2) + XSW'(1) - XSW'(nc);
        wy  = YSW'(py_reg) + YSW'(r2) + YSW'(1) - YSW'(nr);

        border_r.x            = OXW'(px_reg);
        border_r.y            = py_reg;
        border_r.value        = p_reg;
        border_r.filtered     = 1'b0;
        border_r.size_error   = err_reg;
        border_r.last_of_item = 1'b0;
        border_r.frame_done   = 1'b0;

        win_r.x            = OXW'(wx);
        win_r.y            = YW'(wy);
        win_r.value        = row_e;
        win_r.filtered     = 1'b1;
        win_r.size_error   = 1'b0;
        win_r.last_of_item = 1'b0;
        win_r.frame_done   = 1'b0;

        res_a = border_r;
        res_b = win_r;
        res_n = 2'd0;
        if (err_reg) begin
            res_n = 2'd1;
        end else if (!interior && win) begin
            res_n = 2'd2;
        end else if (!interior) begin
            res_n = 2'd1;
        end else if (win) begin
            res_a = win_r;
            res_n = 2'd1;
        end
        if (res_n == 2'd1) begin
            res_a.last_of_item = 1'b1;
            res_a.frame_done   = last_reg;
        end else if (res_n == 2'd2) begin
            res_b.last_of_item = 1'b1;
            res_b.frame_done   = last_reg;
        end
    end

    assign q_push = (state_reg == S_OUT) && (res_n <= q_free);

    gedw_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_n     (res_n),
        .item_a     (res_a),
        .item_b     (res_b),
        .pop_ready  (m_ready),
        .head       (q_head),
        .head_valid (m_valid),
        .free       (q_free)
    );

    assign m_out_x        = q_head.x;
    assign m_out_y        = q_head.y;
    assign m_out_value    = q_head.value;
    assign m_is_filtered  = q_head.filtered;
    assign m_size_error   = q_head.size_error;
    assign m_last_of_item = q_head.last_of_item;
    assign m_frame_done   = q_head.frame_done;

`ifndef SYNTHESIS
    a_one_pixel_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second pixel taken while one is in work");

    a_write_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> $past(s_valid && s_ready))
        else $error("line memory written without a preceding read");

    a_filtered_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_filtered) |-> !m_size_error)
        else $error("window result carries size error");

    a_cfg_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (x_reg == '0 && y_reg == '0 && slot_reg == '0))
        else $error("register write did not restart the region");
`endif

endmodule
